// File: hdl/ghqr_pkg.sv
// Package for the Givens Hessenberg QR update core.
// Holds command codes, status codes, fixed-point helpers and the cell link type.
// No dependencies.
package ghqr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam logic signed [WORD_W-1:0] ONE_Q = 32'sh0001_0000;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_ENTRY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // value handed from one cell to the next along the chain
  // index counts down to the cell that applies its rotation
  typedef struct packed {
    logic                     valid;
    logic [7:0]               index;
    logic signed [WORD_W-1:0] carry;
    logic signed [WORD_W-1:0] entry;
  } link_t;

  // round half up, shift 16, saturate to 32 bits
  function automatic logic signed [WORD_W-1:0] q_round(input logic signed [65:0] p);
    logic signed [65:0] s;
    begin
      s = (p + 66'sd32768) >>> FRAC_W;
      if (s > 66'sd2147483647) q_round = 32'sh7fff_ffff;
      else if (s < -66'sd2147483648) q_round = 32'sh8000_0000;
      else q_round = s[WORD_W-1:0];
    end
  endfunction

  function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
    begin
      mag32 = v[WORD_W-1] ? (~v) + 32'd1 : v;
    end
  endfunction

endpackage

// File: hdl/ghqr_rot_cell.sv
// One rotation cell of the chain: applies the stored rotation of one row.
// Depends on ghqr_pkg.
module ghqr_rot_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clear,
  input  logic                               load,
  input  logic signed [ghqr_pkg::WORD_W-1:0] load_c,
  input  logic signed [ghqr_pkg::WORD_W-1:0] load_s,
  input  ghqr_pkg::link_t                    link_in,
  output ghqr_pkg::link_t                    link_out
);
  import ghqr_pkg::*;

  logic signed [WORD_W-1:0] cos_r, sin_r;
  logic signed [63:0] pca, psv, psa, pcv;
  logic apply;

  // only the cell whose countdown is zero rotates; the others pass through
  assign apply = (link_in.index == '0);

  always_comb begin
    pca = cos_r * link_in.carry;
    psv = sin_r * link_in.entry;
    psa = sin_r * link_in.carry;
    pcv = cos_r * link_in.entry;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cos_r <= '0;
      sin_r <= '0;
    end else if (load) begin
      cos_r <= load_c;
      sin_r <= load_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else begin
      link_out.valid <= link_in.valid;
    end
    link_out.index <= link_in.index - 8'd1;
    link_out.entry <= apply ? q_round(66'(pca) + 66'(psv)) : link_in.entry;
    link_out.carry <= apply ? q_round(66'(pcv) - 66'(psa)) : link_in.carry;
  end
endmodule

// File: hdl/ghqr_sqrt_div.sv
// Sequential norm, cosine/sine and gamma unit for the column-ending entry.
// Depends on ghqr_pkg.
module ghqr_sqrt_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic signed [ghqr_pkg::WORD_W-1:0] a,
  input  logic signed [ghqr_pkg::WORD_W-1:0] v,
  input  logic signed [ghqr_pkg::WORD_W-1:0] gamma,
  output logic                               done,
  output logic signed [ghqr_pkg::WORD_W-1:0] c_out,
  output logic signed [ghqr_pkg::WORD_W-1:0] s_out,
  output logic signed [ghqr_pkg::WORD_W-1:0] diag,
  output logic signed [ghqr_pkg::WORD_W-1:0] g_new,
  output logic signed [ghqr_pkg::WORD_W-1:0] g_next,
  output logic                               zero
);
  import ghqr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SQRT, S_DIVC, S_DIVS, S_MUL, S_FIN} st_t;
  st_t st;
  logic [5:0] cnt;
  logic [64:0] rem, x;
  logic [32:0] root;
  logic [63:0] sq, sqv;
  logic [48:0] num, dq;
  logic [32:0] q;
  logic signed [WORD_W-1:0] ra, rv, rg;
  logic [WORD_W-1:0] ma, mv;
  logic [64:0] trial;
  logic [49:0] dtrial;
  logic signed [63:0] p0, p1, p2, p3;
  logic [32:0] qr;
  logic signed [WORD_W-1:0] qs;

  assign trial = {rem[62:0], x[63:62]} - {30'd0, root, 2'b01};
  assign dtrial = {dq[47:0], num[48]} - {17'd0, root};
  always_comb begin
    qr = (q > 33'd65536) ? 33'd65536 : q;
    qs = WORD_W'(qr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: if (go) begin
          ra <= a; rv <= v; rg <= gamma;
          ma <= mag32(a); mv <= mag32(v);
          st <= S_SQ;
        end
        S_SQ: begin
          sq <= ma * ma;
          sqv <= mv * mv;
          st <= S_SQRT;
          cnt <= 6'd0;
        end
        S_SQRT: begin
          if (cnt == 6'd0) begin
            x <= 65'(sq) + 65'(sqv);
            rem <= '0;
            root <= '0;
            cnt <= 6'd1;
          end else begin
            if (!trial[64]) begin
              rem <= trial;
              root <= {root[31:0], 1'b1};
            end else begin
              rem <= {rem[62:0], x[63:62]};
              root <= {root[31:0], 1'b0};
            end
            x <= {x[62:0], 2'b00};
            if (cnt == 6'd32) begin
              st <= S_DIVC;
              cnt <= 6'd0;
            end else cnt <= cnt + 6'd1;
          end
        end
        S_DIVC, S_DIVS: begin
          if (cnt == 6'd0) begin
            num <= {1'b0, (st == S_DIVC ? ma : mv), 16'd0} + 49'(root[32:1]);
            dq <= '0;
            q <= '0;
            cnt <= 6'd1;
            zero <= (root == 33'd0);
          end else begin
            if (!dtrial[49] && root != 33'd0) begin
              dq <= dtrial[48:0];
              q <= {q[31:0], 1'b1};
            end else begin
              dq <= {dq[47:0], num[48]};
              q <= {q[31:0], 1'b0};
            end
            num <= {num[47:0], 1'b0};
            if (cnt == 6'd49) begin
              cnt <= 6'd0;
              st <= (st == S_DIVC) ? S_DIVS : S_MUL;
            end else cnt <= cnt + 6'd1;
          end
        end
        S_MUL: begin
          if (cnt == 6'd0) begin
            s_out <= zero ? '0 : (rv[WORD_W-1] ? -qs : qs);
            cnt <= 6'd1;
          end else begin
            st <= S_FIN;
          end
        end
        S_FIN: begin
          diag <= q_round(66'(p0) + 66'(p1));
          g_next <= q_round(-66'(p2));
          g_new <= q_round(66'(p3));
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
      // cosine quotient is still held while the sine division starts
      if (st == S_DIVS && cnt == 6'd0) begin
        c_out <= zero ? ONE_Q : (ra[WORD_W-1] ? -qs : qs);
      end
    end
  end

  always_comb begin
    p0 = c_out * ra;
    p1 = s_out * rv;
    p2 = s_out * rg;
    p3 = c_out * rg;
  end
endmodule

// File: hdl/givens_hessenberg_qr_update_core.sv
// Givens Hessenberg QR update core, signed Q16.16; needs ghqr_pkg, ghqr_rot_cell, ghqr_sqrt_div.
// Start and entry-0 requests give no result; an overflow entry's result is registered at accept.
// Rotated entries pass the MAX_COLUMNS-cell chain before their result is registered.
// Column-ending entry runs the norm/divide unit; its result is registered when the unit is done.
// One request in flight; the next can be accepted in the cycle after the result is taken.
// Synchronous active-high reset clears all rotations, gamma and counters.
module givens_hessenberg_qr_update_core #(
  parameter int MAX_COLUMNS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // value
  input  logic         s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // rotated_entry, gamma_entry, residual, status, zeros
  output logic         m_tlast    // column_done
);
  import ghqr_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int NC = MAX_COLUMNS;

  typedef enum logic [2:0] {IDLE, CHAIN, NORM, OUT} st_t;
  st_t st;

  logic [CW-1:0] col, elem, cnt;
  logic signed [WORD_W-1:0] gam, carry, vin, held_v;
  link_t links [0:NC];
  logic [NC-1:0] load;
  logic sd_go, sd_done, sd_zero;
  logic signed [WORD_W-1:0] sd_c, sd_s, sd_diag, sd_gn, sd_gx;
  logic signed [WORD_W-1:0] o_rot, o_gam;
  logic [30:0] o_res;
  status_t o_st;
  logic [WORD_W-1:0] gmag;
  logic clr;

  assign vin = s_tdata;
  assign s_tready = (st == IDLE) && !m_tvalid;
  assign clr = s_tvalid && s_tready && s_tuser == CMD_START;
  assign gmag = mag32(sd_gx);

  // chain entry held stable through the cells
  assign links[0] = '{valid: (st == CHAIN) && (cnt == '0), index: 8'(elem - CW'(1)),
                      carry: carry, entry: held_v};

  genvar g;
  generate
    for (g = 0; g < NC; g++) begin : g_cell
      assign load[g] = sd_done && (col == CW'(g));
      ghqr_rot_cell u_cell (
        .clk(clk), .rst(rst), .clear(clr), .load(load[g]),
        .load_c(sd_c), .load_s(sd_s),
        .link_in(links[g]), .link_out(links[g+1])
      );
    end
  endgenerate

  assign sd_go = (st == NORM) && (cnt == '0);

  ghqr_sqrt_div u_sd (
    .clk(clk), .rst(rst), .go(sd_go), .a(carry), .v(held_v), .gamma(gam),
    .done(sd_done), .c_out(sd_c), .s_out(sd_s), .diag(sd_diag),
    .g_new(sd_gn), .g_next(sd_gx), .zero(sd_zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= IDLE; col <= '0; elem <= '0; gam <= '0; carry <= '0;
      m_tvalid <= 1'b0; cnt <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (st)
        IDLE: if (s_tvalid && s_tready) begin
          held_v <= vin;
          if (s_tuser == CMD_START) begin
            gam <= vin; carry <= '0; elem <= '0; col <= '0;
          end else if (col >= CW'(MAX_COLUMNS)) begin
            o_rot <= '0; o_gam <= '0; o_res <= '0; o_st <= ST_OVERFLOW;
            m_tlast <= 1'b0; m_tvalid <= 1'b1;
          end else if (elem == '0) begin
            carry <= vin; elem <= CW'(1);
          end else if (elem <= col) begin
            st <= CHAIN; cnt <= '0;
          end else begin
            st <= NORM; cnt <= '0;
          end
        end
        CHAIN: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NC)) begin
            o_rot <= links[NC].entry; carry <= links[NC].carry;
            o_gam <= '0; o_res <= '0; o_st <= ST_OK; m_tlast <= 1'b0;
            m_tvalid <= 1'b1; elem <= elem + CW'(1); st <= IDLE;
          end
        end
        NORM: begin
          cnt <= CW'(1);
          if (sd_done) begin
            o_rot <= sd_diag; o_gam <= sd_gn;
            o_res <= (gmag > 32'h7fff_ffff) ? 31'h7fff_ffff : gmag[30:0];
            o_st <= sd_zero ? ST_ZERO : ST_OK; m_tlast <= 1'b1; m_tvalid <= 1'b1;
            gam <= sd_gx; carry <= '0; elem <= '0; col <= col + CW'(1);
            st <= IDLE;
          end
        end
        default: st <= IDLE;
      endcase
    end
  end

  assign m_tdata = {7'd0, o_st, o_res, o_gam, o_rot};

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid);
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast));
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= CW'(MAX_COLUMNS));
  a_done_norm: assert property (@(posedge clk) disable iff (rst)
    sd_done |-> st == NORM);
endmodule
